@@ src/dpps_pkg.sv @@
// ----------------------------------------------------------------------------
// dpps_pkg - shared types and constants of the dual pulse / PCM sound unit
// Beat payloads, decoded operations, bus addresses and the lookup tables.
// ----------------------------------------------------------------------------
`default_nettype none

package dpps_pkg;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  localparam logic [15:0] ADDR_CTRL_ONE = 16'h5000;
  localparam logic [15:0] ADDR_LOW_ONE  = 16'h5002;
  localparam logic [15:0] ADDR_HIGH_ONE = 16'h5003;
  localparam logic [15:0] ADDR_CTRL_TWO = 16'h5004;
  localparam logic [15:0] ADDR_LOW_TWO  = 16'h5006;
  localparam logic [15:0] ADDR_HIGH_TWO = 16'h5007;
  localparam logic [15:0] ADDR_PCM      = 16'h5011;
  localparam logic [15:0] ADDR_STATUS   = 16'h5015;

  localparam logic [1:0] REG_EN_PULSE_ONE = 2'd0;
  localparam logic [1:0] REG_EN_PULSE_TWO = 2'd1;
  localparam logic [1:0] REG_EN_PCM       = 2'd2;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 1;
  localparam int unsigned NumChan  = 2;
  localparam int unsigned QDepth   = 2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] address;
    logic [7:0]  data;
    logic [15:0] cycles;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [3:0] pulse_one_level;
    logic [3:0] pulse_two_level;
    logic [7:0] pcm_level;
    logic [9:0] mix_numerator;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_CTRL,
    OP_PERIOD_LO,
    OP_PERIOD_HI,
    OP_PCM,
    OP_CLAMP,
    OP_STATUS,
    OP_TICK
  } op_e;

  typedef struct packed {
    op_e         op;
    logic        chan;
    logic [7:0]  data;
    logic [15:0] cycles;
  } op_t;

  function automatic logic [7:0] len_lookup(input logic [4:0] idx);
    logic [7:0] v;
    unique case (idx)
      5'd0:  v = 8'h0A;
      5'd1:  v = 8'h14;
      5'd2:  v = 8'h28;
      5'd3:  v = 8'h50;
      5'd4:  v = 8'hA0;
      5'd5:  v = 8'h3C;
      5'd6:  v = 8'h0E;
      5'd7:  v = 8'h1A;
      5'd8:  v = 8'h0C;
      5'd9:  v = 8'h18;
      5'd10: v = 8'h30;
      5'd11: v = 8'h60;
      5'd12: v = 8'hC0;
      5'd13: v = 8'h48;
      5'd14: v = 8'h10;
      5'd15: v = 8'h20;
      5'd16: v = 8'hFE;
      5'd17: v = 8'h02;
      5'd18: v = 8'h04;
      5'd19: v = 8'h06;
      5'd20: v = 8'h08;
      5'd21: v = 8'h0A;
      5'd22: v = 8'h0C;
      5'd23: v = 8'h0E;
      5'd24: v = 8'h10;
      5'd25: v = 8'h12;
      5'd26: v = 8'h14;
      5'd27: v = 8'h16;
      5'd28: v = 8'h18;
      5'd29: v = 8'h1A;
      5'd30: v = 8'h1C;
      5'd31: v = 8'h1E;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic duty_high(input logic [1:0] duty, input logic [2:0] step);
    logic [7:0] pat;
    unique case (duty)
      2'd0:    pat = 8'b0000_0010;
      2'd1:    pat = 8'b0000_0110;
      2'd2:    pat = 8'b0001_1110;
      2'd3:    pat = 8'b1111_1001;
      default: pat = 8'b0000_0000;
    endcase
    return pat[step];
  endfunction

endpackage

`default_nettype wire

@@ src/dpps_front.sv @@
// ----------------------------------------------------------------------------
// dpps_front - input side of the sound unit
// Accepts bus and tick beats and classifies them into queue operations.
// ----------------------------------------------------------------------------
`default_nettype none

module dpps_front (
  input  wire logic              in_valid_i,
  input  wire dpps_pkg::in_item_t in_item_i,
  output logic                   in_stall_o,
  input  wire logic              q_full_i,
  output logic                   q_push_o,
  output dpps_pkg::op_t          q_op_o
);
  import dpps_pkg::*;

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i & ~q_full_i;

  always_comb begin
    q_op_o.op     = OP_NONE;
    q_op_o.chan   = 1'b0;
    q_op_o.data   = in_item_i.data;
    q_op_o.cycles = in_item_i.cycles;
    priority if (in_item_i.cmd == CMD_WRITE) begin
      priority if (in_item_i.address == ADDR_CTRL_ONE) begin
        q_op_o.op = OP_CTRL;
      end else if (in_item_i.address == ADDR_LOW_ONE) begin
        q_op_o.op = OP_PERIOD_LO;
      end else if (in_item_i.address == ADDR_HIGH_ONE) begin
        q_op_o.op = OP_PERIOD_HI;
      end else if (in_item_i.address == ADDR_CTRL_TWO) begin
        q_op_o.op   = OP_CTRL;
        q_op_o.chan = 1'b1;
      end else if (in_item_i.address == ADDR_LOW_TWO) begin
        q_op_o.op   = OP_PERIOD_LO;
        q_op_o.chan = 1'b1;
      end else if (in_item_i.address == ADDR_HIGH_TWO) begin
        q_op_o.op   = OP_PERIOD_HI;
        q_op_o.chan = 1'b1;
      end else if (in_item_i.address == ADDR_PCM) begin
        q_op_o.op = OP_PCM;
      end else if (in_item_i.address == ADDR_STATUS) begin
        q_op_o.op = OP_CLAMP;
      end else begin
        q_op_o.op = OP_NONE;
      end
    end else if (in_item_i.cmd == CMD_READ) begin
      q_op_o.op = (in_item_i.address == ADDR_STATUS) ? OP_STATUS : OP_NONE;
    end else if (in_item_i.cmd == CMD_TICK) begin
      q_op_o.op = OP_TICK;
    end else begin
      q_op_o.op = OP_NONE;
    end
  end

endmodule

`default_nettype wire

@@ src/dpps_queue.sv @@
// ----------------------------------------------------------------------------
// dpps_queue - operation queue between front and back
// Short FIFO of decoded operations; each side stalls on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module dpps_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire dpps_pkg::op_t push_op_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               valid_o,
  output dpps_pkg::op_t      head_op_o
);
  import dpps_pkg::*;

  localparam int unsigned PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned CntW = $clog2(QDepth + 1);

  op_t            mem_q [QDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o    = (count_q == CntW'(QDepth));
  assign valid_o   = (count_q != '0);
  assign head_op_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_op_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> count_q != '0)
    else $error("queue popped while empty");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> count_q == $past(count_q) + 1'b1)
    else $error("queue count lost a push");

endmodule

`default_nettype wire

@@ src/dpps_back.sv @@
// ----------------------------------------------------------------------------
// dpps_back - execution side of the sound unit
// Holds channel state; one op a cycle unless stalled; result registered.
// ----------------------------------------------------------------------------
`default_nettype none

module dpps_back (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [dpps_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [dpps_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                         q_valid_i,
  input  wire dpps_pkg::op_t                q_op_i,
  output logic                              q_pop_o,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output dpps_pkg::out_item_t               out_item_o
);
  import dpps_pkg::*;

  logic        en_q [NumChan];
  logic        en_pcm_q;

  logic signed [17:0] cd_q   [NumChan];
  logic signed [17:0] cd_d   [NumChan];
  logic signed [17:0] cd_t   [NumChan];
  logic [12:0]        reload [NumChan];
  logic [10:0] period_q [NumChan], period_d [NumChan];
  logic [7:0]  len_q    [NumChan], len_d    [NumChan];
  logic [3:0]  vol_q    [NumChan], vol_d    [NumChan];
  logic [1:0]  duty_q   [NumChan], duty_d   [NumChan];
  logic        clamp_q  [NumChan], clamp_d  [NumChan];
  logic [2:0]  step_q   [NumChan], step_d   [NumChan];
  logic [3:0]  level_q  [NumChan], level_d  [NumChan];
  logic [7:0]  pcm_q, pcm_d;

  logic        out_valid_q;
  out_item_t   out_q, out_d;
  logic [7:0]  rd;
  logic [9:0]  mix;
  op_e         op_sel;

  assign q_pop_o     = q_valid_i & (~out_valid_q | ~out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign op_sel      = q_valid_i ? q_op_i.op : OP_NONE;

  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      reload[c] = {1'b0, period_q[c], 1'b0} + 13'd4;
      cd_t[c]   = (cd_q[c] > 18'sd0) ? cd_q[c] - $signed({2'b00, q_op_i.cycles}) : cd_q[c];
    end
  end

  always_comb begin
    pcm_d = pcm_q;
    rd    = 8'h00;
    for (int c = 0; c < NumChan; c++) begin
      cd_d[c]     = cd_q[c];
      period_d[c] = period_q[c];
      len_d[c]    = len_q[c];
      vol_d[c]    = vol_q[c];
      duty_d[c]   = duty_q[c];
      clamp_d[c]  = clamp_q[c];
      step_d[c]   = step_q[c];
      level_d[c]  = level_q[c];
      unique case (op_sel)
        OP_CTRL: begin
          if (q_op_i.chan == c[0]) begin
            vol_d[c]  = q_op_i.data[3:0];
            duty_d[c] = q_op_i.data[7:6];
          end
        end
        OP_PERIOD_LO: begin
          if (q_op_i.chan == c[0]) begin
            period_d[c][7:0] = q_op_i.data;
          end
        end
        OP_PERIOD_HI: begin
          if (q_op_i.chan == c[0]) begin
            period_d[c][10:8] = q_op_i.data[2:0];
            if (!clamp_q[c]) begin
              len_d[c] = len_lookup(q_op_i.data[7:3]);
            end
            step_d[c] = 3'd0;
          end
        end
        OP_CLAMP: begin
          clamp_d[c] = q_op_i.data[c];
          if (q_op_i.data[c]) begin
            len_d[c] = 8'h00;
          end
        end
        OP_STATUS: begin
          rd[c] = (len_q[c] != 8'h00);
        end
        OP_TICK: begin
          if (en_q[c]) begin
            if (cd_t[c] > 18'sd0) begin
              cd_d[c] = cd_t[c];
            end else begin
              cd_d[c]    = cd_t[c] + $signed({5'b00000, reload[c]});
              level_d[c] = (len_q[c] != 8'h00 && duty_high(duty_q[c], step_q[c]))
                           ? vol_q[c] : 4'h0;
              step_d[c]  = step_q[c] + 3'd1;
            end
          end
        end
        OP_PCM, OP_NONE: begin
        end
        default: begin
        end
      endcase
    end
    if (op_sel == OP_PCM) begin
      pcm_d = q_op_i.data;
    end
  end

  always_comb begin
    mix = 10'd0;
    for (int c = 0; c < NumChan; c++) begin
      if (en_q[c]) begin
        mix = mix + {2'b00, level_d[c], 4'h0} + {6'd0, level_d[c]};
      end
    end
    if (en_pcm_q) begin
      mix = mix + {2'b00, pcm_d};
    end
    out_d.read_data       = rd;
    out_d.pulse_one_level = level_d[0];
    out_d.pulse_two_level = level_d[1];
    out_d.pcm_level       = pcm_d;
    out_d.mix_numerator   = mix;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q[0]  <= 1'b1;
      en_q[1]  <= 1'b1;
      en_pcm_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_EN_PULSE_ONE: en_q[0]  <= cfg_data_i[0];
        REG_EN_PULSE_TWO: en_q[1]  <= cfg_data_i[0];
        REG_EN_PCM:       en_pcm_q <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NumChan; c++) begin
        cd_q[c]     <= '0;
        period_q[c] <= '0;
        len_q[c]    <= '0;
        vol_q[c]    <= '0;
        duty_q[c]   <= '0;
        clamp_q[c]  <= 1'b0;
        step_q[c]   <= '0;
        level_q[c]  <= '0;
      end
      pcm_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        for (int c = 0; c < NumChan; c++) begin
          cd_q[c]     <= cd_d[c];
          period_q[c] <= period_d[c];
          len_q[c]    <= len_d[c];
          vol_q[c]    <= vol_d[c];
          duty_q[c]   <= duty_d[c];
          clamp_q[c]  <= clamp_d[c];
          step_q[c]   <= step_d[c];
          level_q[c]  <= level_d[c];
        end
        pcm_q       <= pcm_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_q <= out_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!clamp_q[0] || len_q[0] == 8'h00) && (!clamp_q[1] || len_q[1] == 8'h00))
    else $error("clamped channel holds a nonzero length");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cd_q[0] <= 18'sd4098 && cd_q[0] >= -18'sd65530 &&
    cd_q[1] <= 18'sd4098 && cd_q[1] >= -18'sd65530)
    else $error("countdown out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.mix_numerator <= 10'd765)
    else $error("mix numerator above full scale");

endmodule

`default_nettype wire

@@ src/dual_pulse_pcm_sound_unit.sv @@
// ----------------------------------------------------------------------------
// dual_pulse_pcm_sound_unit - two pulse channels and a raw PCM level
// Bus writes, status reads and cycle ticks in; one level/mix beat out each.
// ----------------------------------------------------------------------------
// Takes one input beat per clock while the queue is not full, and returns
// exactly one result beat for each, in order. An accepted beat is decoded into
// a two-entry queue; when the back end pops it, its result is registered in
// the output register. The back end takes one beat per cycle while the output
// is not stalled. The queue and the output register let the input keep taking
// beats until the queue is full while a result waits to be taken. Enable
// registers are to be written by the user through the config port only while
// the unit is idle; the block itself does not enforce this.
`default_nettype none

module dual_pulse_pcm_sound_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [dpps_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [dpps_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                         in_valid_i,
  input  wire dpps_pkg::in_item_t           in_item_i,
  output logic                              in_stall_o,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output dpps_pkg::out_item_t               out_item_o
);
  import dpps_pkg::*;

  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_valid;
  op_t  push_op;
  op_t  head_op;

  dpps_front u_front (
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .in_stall_o (in_stall_o),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_op_o     (push_op)
  );

  dpps_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (q_push),
    .push_op_i (push_op),
    .full_o    (q_full),
    .pop_i     (q_pop),
    .valid_o   (q_valid),
    .head_op_o (head_op)
  );

  dpps_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .q_valid_i   (q_valid),
    .q_op_i      (head_op),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire
